@@ design/fpr_pkg.sv @@
package fpr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W = 16;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    localparam logic [1:0] REG_START_FIRST = 2'd0;
    localparam logic [1:0] REG_START_SECOND = 2'd1;
    localparam logic [1:0] REG_END_FIRST = 2'd2;
    localparam logic [1:0] REG_END_SECOND = 2'd3;

    localparam logic [2:0] CLS_LEN = 3'd0;
    localparam logic [2:0] CLS_CMD = 3'd1;
    localparam logic [2:0] CLS_PAY = 3'd2;
    localparam logic [2:0] CLS_CRC_LOW = 3'd3;
    localparam logic [2:0] CLS_CRC_HIGH = 3'd4;
    localparam logic [2:0] CLS_END_BAD = 3'd5;
    localparam logic [2:0] CLS_END_GOOD = 3'd6;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [1:0] STATUS_GOOD = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERROR = 2'd1;
    localparam logic [1:0] STATUS_BAD_END = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] start_first;
        logic [BYTE_W-1:0] start_second;
        logic [BYTE_W-1:0] end_first;
        logic [BYTE_W-1:0] end_second;
    } cfg_t;

    typedef struct packed {
        logic [2:0]        cls;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] index;
    } item_t;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[CRC_W-1])
            begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ design/fpr_front.sv @@
module fpr_front (
    input  logic          clk,
    input  logic          rst_n,
    input  fpr_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    rx_byte,
    output logic          push_valid,
    input  logic          push_ready,
    output fpr_pkg::item_t push_item
);
    import fpr_pkg::*;

    localparam logic [3:0] PH_START_FIRST = 4'd0;
    localparam logic [3:0] PH_START_SECOND = 4'd1;
    localparam logic [3:0] PH_LEN = 4'd2;
    localparam logic [3:0] PH_CMD = 4'd3;
    localparam logic [3:0] PH_PAY = 4'd4;
    localparam logic [3:0] PH_CRC_LOW = 4'd5;
    localparam logic [3:0] PH_CRC_HIGH = 4'd6;
    localparam logic [3:0] PH_END_FIRST = 4'd7;
    localparam logic [3:0] PH_END_SECOND = 4'd8;

    logic [3:0]        phase_reg;
    logic [3:0]        phase_next;
    logic [BYTE_W-1:0] length_reg;
    logic [BYTE_W-1:0] length_next;
    logic [BYTE_W-1:0] seen_reg;
    logic [BYTE_W-1:0] seen_next;
    logic              accept;
    logic [BYTE_W:0]   seen_inc;

    assign in_ready = push_ready;
    assign accept = in_valid && push_ready;
    assign seen_inc = {1'b0, seen_reg} + {{BYTE_W{1'b0}}, 1'b1};

    always_comb
    begin
        phase_next = phase_reg;
        length_next = length_reg;
        seen_next = seen_reg;
        push_valid = 1'b0;
        push_item.cls = CLS_LEN;
        push_item.data = rx_byte;
        push_item.index = seen_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_START_FIRST:
                begin
                    if (rx_byte == cfg.start_first)
                    begin
                        phase_next = PH_START_SECOND;
                    end
                end
                PH_START_SECOND:
                begin
                    phase_next = (rx_byte == cfg.start_second) ? PH_LEN : PH_START_FIRST;
                end
                PH_LEN:
                begin
                    push_valid = 1'b1;
                    push_item.cls = CLS_LEN;
                    length_next = rx_byte;
                    seen_next = '0;
                    phase_next = PH_CMD;
                end
                PH_CMD:
                begin
                    push_valid = 1'b1;
                    push_item.cls = CLS_CMD;
                    phase_next = (length_reg != '0) ? PH_PAY : PH_CRC_LOW;
                end
                PH_PAY:
                begin
                    push_valid = 1'b1;
                    push_item.cls = CLS_PAY;
                    seen_next = seen_inc[BYTE_W-1:0];
                    if (seen_inc >= {1'b0, length_reg})
                    begin
                        phase_next = PH_CRC_LOW;
                    end
                end
                PH_CRC_LOW:
                begin
                    push_valid = 1'b1;
                    push_item.cls = CLS_CRC_LOW;
                    phase_next = PH_CRC_HIGH;
                end
                PH_CRC_HIGH:
                begin
                    push_valid = 1'b1;
                    push_item.cls = CLS_CRC_HIGH;
                    phase_next = PH_END_FIRST;
                end
                PH_END_FIRST:
                begin
                    if (rx_byte == cfg.end_first)
                    begin
                        phase_next = PH_END_SECOND;
                    end
                    else
                    begin
                        push_valid = 1'b1;
                        push_item.cls = CLS_END_BAD;
                        phase_next = PH_START_FIRST;
                    end
                end
                PH_END_SECOND:
                begin
                    push_valid = 1'b1;
                    push_item.cls = (rx_byte == cfg.end_second) ? CLS_END_GOOD : CLS_END_BAD;
                    phase_next = PH_START_FIRST;
                end
                default:
                begin
                    phase_next = PH_START_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START_FIRST;
            length_reg <= '0;
            seen_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            length_reg <= length_next;
            seen_reg <= seen_next;
        end
    end

endmodule

@@ design/fpr_fifo.sv @@
module fpr_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  fpr_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output fpr_pkg::item_t pop_item
);
    import fpr_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    item_t            store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item = store_reg[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

@@ design/fpr_back.sv @@
module fpr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  fpr_pkg::item_t pop_item,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           result_kind,
    output logic [7:0]     payload_byte,
    output logic [7:0]     payload_index,
    output logic [7:0]     frame_command,
    output logic [7:0]     frame_length,
    output logic [1:0]     frame_status
);
    import fpr_pkg::*;

    logic [BYTE_W-1:0] length_reg;
    logic [BYTE_W-1:0] command_reg;
    logic [CRC_W-1:0]  crc_reg;
    logic [BYTE_W-1:0] crc_low_reg;
    logic              matched_reg;
    logic              out_valid_reg;
    logic              kind_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] index_reg;
    logic [BYTE_W-1:0] command_out_reg;
    logic [BYTE_W-1:0] length_out_reg;
    logic [1:0]        status_reg;
    logic              slot_free;
    logic              makes_result;
    logic              take;
    logic [CRC_W-1:0]  crc_upd;

    assign slot_free = !out_valid_reg || out_ready;
    assign makes_result = (pop_item.cls == CLS_PAY) || (pop_item.cls == CLS_END_BAD)
                          || (pop_item.cls == CLS_END_GOOD);
    assign pop_ready = !makes_result || slot_free;
    assign take = pop_valid && pop_ready;
    assign crc_upd = crc_byte((pop_item.cls == CLS_LEN) ? CRC_INIT : crc_reg, pop_item.data);

    assign out_valid = out_valid_reg;
    assign result_kind = kind_reg;
    assign payload_byte = byte_reg;
    assign payload_index = index_reg;
    assign frame_command = command_out_reg;
    assign frame_length = length_out_reg;
    assign frame_status = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            command_reg <= '0;
            crc_reg <= CRC_INIT;
            crc_low_reg <= '0;
            matched_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (take)
            begin
                case (pop_item.cls)
                    CLS_LEN:
                    begin
                        length_reg <= pop_item.data;
                        crc_reg <= crc_upd;
                    end
                    CLS_CMD:
                    begin
                        command_reg <= pop_item.data;
                        crc_reg <= crc_upd;
                    end
                    CLS_PAY:
                    begin
                        crc_reg <= crc_upd;
                        out_valid_reg <= 1'b1;
                    end
                    CLS_CRC_LOW:
                    begin
                        crc_low_reg <= pop_item.data;
                    end
                    CLS_CRC_HIGH:
                    begin
                        matched_reg <= ({pop_item.data, crc_low_reg} == crc_reg);
                    end
                    CLS_END_BAD, CLS_END_GOOD:
                    begin
                        out_valid_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && makes_result)
        begin
            command_out_reg <= command_reg;
            length_out_reg <= length_reg;
            if (pop_item.cls == CLS_PAY)
            begin
                kind_reg <= KIND_PAYLOAD;
                byte_reg <= pop_item.data;
                index_reg <= pop_item.index;
                status_reg <= STATUS_GOOD;
            end
            else
            begin
                kind_reg <= KIND_REPORT;
                byte_reg <= '0;
                index_reg <= '0;
                if (pop_item.cls == CLS_END_BAD)
                begin
                    status_reg <= STATUS_BAD_END;
                end
                else
                begin
                    status_reg <= matched_reg ? STATUS_GOOD : STATUS_CRC_ERROR;
                end
            end
        end
    end

endmodule

@@ design/framed_packet_receiver.sv @@
// Channel   Handshake             Payload
// input     in_valid / in_ready   rx_byte
// output    out_valid / out_ready result_kind, payload_byte, payload_index,
//                                 frame_command, frame_length, frame_status
// config    cfg_write             cfg_index, cfg_data
//
// One byte is taken per cycle while the queue has room; a result passes the queue and then the output registers.
// The front parser and the CRC back end are parted by a queue of QUEUE_DEPTH
// entries, so the input keeps flowing while a result waits on the output.
// A stalled output fills the queue, and the input stalls only once it is full.
// Reset is asynchronous and active low and restores the default markers.
module framed_packet_receiver #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       result_kind,
    output logic [7:0] payload_byte,
    output logic [7:0] payload_index,
    output logic [7:0] frame_command,
    output logic [7:0] frame_length,
    output logic [1:0] frame_status
);
    import fpr_pkg::*;

    cfg_t  cfg_reg;
    item_t push_item;
    item_t pop_item;
    logic  push_valid;
    logic  push_ready;
    logic  pop_valid;
    logic  pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_first <= 8'hA5;
            cfg_reg.start_second <= 8'h5A;
            cfg_reg.end_first <= 8'h5A;
            cfg_reg.end_second <= 8'hA5;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_START_FIRST: cfg_reg.start_first <= cfg_data;
                REG_START_SECOND: cfg_reg.start_second <= cfg_data;
                REG_END_FIRST: cfg_reg.end_first <= cfg_data;
                REG_END_SECOND: cfg_reg.end_second <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    fpr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    fpr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    fpr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .frame_command (frame_command),
        .frame_length  (frame_length),
        .frame_status  (frame_status)
    );

endmodule

@@ bench/tb_framed_packet_receiver.sv @@
module tb_framed_packet_receiver;

    import fpr_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 16;

    typedef enum logic [3:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        TAKE_LENGTH,
        TAKE_COMMAND,
        TAKE_PAYLOAD,
        TAKE_CRC_LOW,
        TAKE_CRC_HIGH,
        TAKE_END_FIRST,
        TAKE_END_SECOND
    } deframe_phase_t;

    typedef enum int {
        CLOSE_GOOD,
        CLOSE_BAD_FIRST,
        CLOSE_BAD_SECOND
    } frame_close_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] index;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] length;
        logic [1:0]        status;
    } frame_event_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_command;
    logic [7:0] frame_length;
    logic [1:0] frame_status;

    framed_packet_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .frame_command (frame_command),
        .frame_length  (frame_length),
        .frame_status  (frame_status)
    );

    cfg_t              markers;
    deframe_phase_t    parse_phase;
    logic [BYTE_W-1:0] announced_len;
    logic [BYTE_W-1:0] held_command;
    logic [BYTE_W-1:0] payload_count;
    logic [CRC_W-1:0]  crc_acc;
    logic [BYTE_W-1:0] crc_low;
    logic              crc_ok;

    logic [7:0]   link_bytes[$];
    frame_event_t frame_events_due[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_queued = 0;
    int bytes_sent = 0;
    int payloads_checked = 0;
    int reports_checked = 0;
    int report_tally[3] = '{0, 0, 0};
    int error_count = 0;
    int stall_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
                                                       input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] acc;
        acc = crc;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (acc[CRC_W-1] ^ data[i])
            begin
                acc = {acc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                acc = {acc[CRC_W-2:0], 1'b0};
            end
        end
        return acc;
    endfunction

    task automatic push_report(input logic [1:0] status);
        frame_event_t ev;
        ev = '{KIND_REPORT, 8'h00, 8'h00, held_command, announced_len, status};
        frame_events_due.push_back(ev);
        parse_phase = HUNT_FIRST;
    endtask

    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        frame_event_t ev;
        case (parse_phase)
            HUNT_FIRST:
            begin
                if (b == markers.start_first)
                begin
                    parse_phase = HUNT_SECOND;
                end
            end
            HUNT_SECOND:
            begin
                parse_phase = (b == markers.start_second) ? TAKE_LENGTH : HUNT_FIRST;
            end
            TAKE_LENGTH:
            begin
                announced_len = b;
                payload_count = '0;
                crc_acc = crc16_update(CRC_INIT, b);
                parse_phase = TAKE_COMMAND;
            end
            TAKE_COMMAND:
            begin
                held_command = b;
                crc_acc = crc16_update(crc_acc, b);
                parse_phase = (announced_len != 0) ? TAKE_PAYLOAD : TAKE_CRC_LOW;
            end
            TAKE_PAYLOAD:
            begin
                crc_acc = crc16_update(crc_acc, b);
                ev = '{KIND_PAYLOAD, b, payload_count, held_command, announced_len,
                       STATUS_GOOD};
                frame_events_due.push_back(ev);
                payload_count = payload_count + 8'd1;
                if (payload_count >= announced_len)
                begin
                    parse_phase = TAKE_CRC_LOW;
                end
            end
            TAKE_CRC_LOW:
            begin
                crc_low = b;
                parse_phase = TAKE_CRC_HIGH;
            end
            TAKE_CRC_HIGH:
            begin
                crc_ok = ({b, crc_low} == crc_acc);
                parse_phase = TAKE_END_FIRST;
            end
            TAKE_END_FIRST:
            begin
                if (b == markers.end_first)
                begin
                    parse_phase = TAKE_END_SECOND;
                end
                else
                begin
                    push_report(STATUS_BAD_END);
                end
            end
            TAKE_END_SECOND:
            begin
                if (b == markers.end_second)
                begin
                    push_report(crc_ok ? STATUS_GOOD : STATUS_CRC_ERROR);
                end
                else
                begin
                    push_report(STATUS_BAD_END);
                end
            end
            default:
            begin
                parse_phase = HUNT_FIRST;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                deframe_byte(rx_byte);
                bytes_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (link_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    rx_byte <= link_bytes.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        frame_event_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (frame_events_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual kind %0h data %0h",
                             $time, result_kind, payload_byte);
                    error_count++;
                end
                else
                begin
                    want = frame_events_due.pop_front();
                    check_field("result_kind", 8'(want.kind), 8'(result_kind));
                    check_field("payload_byte", want.data, payload_byte);
                    check_field("payload_index", want.index, payload_index);
                    check_field("frame_command", want.command, frame_command);
                    check_field("frame_length", want.length, frame_length);
                    check_field("frame_status", 8'(want.status), 8'(frame_status));
                    if (want.kind == KIND_REPORT)
                    begin
                        reports_checked++;
                        report_tally[want.status]++;
                    end
                    else
                    begin
                        payloads_checked++;
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cycles <= 0;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timeout after %0d cycles without a transfer.", stall_cycles);
                $display("framed_packet_receiver test failed");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        link_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_frame(input logic [7:0] len, input logic [7:0] command,
                               input bit crc_good, input frame_close_t close_kind);
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] b;
        push_byte(markers.start_first);
        push_byte(markers.start_second);
        push_byte(len);
        crc = crc16_update(CRC_INIT, len);
        push_byte(command);
        crc = crc16_update(crc, command);
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(0, 255));
            push_byte(b);
            crc = crc16_update(crc, b);
        end
        if (!crc_good)
        begin
            crc = crc ^ 16'($urandom_range(1, 65535));
        end
        push_byte(crc[7:0]);
        push_byte(crc[15:8]);
        case (close_kind)
            CLOSE_GOOD:
            begin
                push_byte(markers.end_first);
                push_byte(markers.end_second);
            end
            CLOSE_BAD_FIRST:
            begin
                push_byte(markers.end_first ^ 8'($urandom_range(1, 255)));
            end
            default:
            begin
                push_byte(markers.end_first);
                push_byte(markers.end_second ^ 8'($urandom_range(1, 255)));
            end
        endcase
    endtask

    task automatic random_traffic(input int budget);
        int           target;
        int           pick;
        int           len;
        int           extra;
        frame_close_t close_kind;
        target = bytes_queued + budget;
        while (bytes_queued < target)
        begin
            pick = $urandom_range(0, 99);
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            if (pick < 70)
            begin
                case ($urandom_range(0, 9))
                    0: close_kind = CLOSE_BAD_FIRST;
                    1: close_kind = CLOSE_BAD_SECOND;
                    default: close_kind = CLOSE_GOOD;
                endcase
                queue_frame(8'(len), 8'($urandom_range(0, 255)), $urandom_range(0, 9) != 0,
                            close_kind);
            end
            else if (pick < 85)
            begin
                extra = $urandom_range(1, 6);
                for (int i = 0; i < extra; i++)
                begin
                    push_byte(8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                push_byte(markers.start_first);
                if ($urandom_range(0, 1) == 0)
                begin
                    push_byte(markers.start_second ^ 8'($urandom_range(1, 255)));
                end
                else
                begin
                    push_byte(markers.start_second);
                    push_byte(8'($urandom_range(0, 6)));
                    extra = $urandom_range(0, 5);
                    for (int i = 0; i < extra; i++)
                    begin
                        push_byte(8'($urandom_range(0, 255)));
                    end
                end
            end
        end
    endtask

    task automatic drain_link();
        @(negedge clk);
        while (bytes_sent != bytes_queued || frame_events_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_START_FIRST:  markers.start_first = value;
            REG_START_SECOND: markers.start_second = value;
            REG_END_FIRST:    markers.end_first = value;
            default:          markers.end_second = value;
        endcase
    endtask

    task automatic write_markers(input logic [7:0] sf, input logic [7:0] ss,
                                 input logic [7:0] ef, input logic [7:0] es);
        write_register(REG_START_FIRST, sf);
        write_register(REG_START_SECOND, ss);
        write_register(REG_END_FIRST, ef);
        write_register(REG_END_SECOND, es);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        markers = '{8'hA5, 8'h5A, 8'h5A, 8'hA5};
        parse_phase = HUNT_FIRST;
        announced_len = '0;
        held_command = '0;
        payload_count = '0;
        crc_acc = CRC_INIT;
        crc_low = '0;
        crc_ok = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 52;
        push_byte(8'h00);
        push_byte(8'hFF);
        queue_frame(8'd0, 8'h00, 1'b1, CLOSE_GOOD);
        queue_frame(8'd1, 8'hFF, 1'b1, CLOSE_GOOD);
        // A wrong second start byte equal to the first restarts the hunt, so the bytes after it form no frame.
        push_byte(markers.start_first);
        push_byte(markers.start_first);
        push_byte(markers.start_second);
        push_byte(8'd2);
        push_byte(8'h07);
        queue_frame(8'd0, 8'h3C, 1'b0, CLOSE_GOOD);
        queue_frame(8'd0, 8'h81, 1'b1, CLOSE_BAD_FIRST);
        queue_frame(8'd0, 8'h42, 1'b1, CLOSE_BAD_SECOND);
        queue_frame(8'd0, 8'h18, 1'b0, CLOSE_BAD_FIRST);
        random_traffic(225);

        for (int setting = 1; setting < 6; setting++)
        begin
            drain_link();
            case (setting)
                1: write_markers(8'h00, 8'h00, 8'h00, 8'h00);
                2: write_markers(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                3: write_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                4: write_markers(8'h00, 8'hFF, 8'hFF, 8'h00);
                default: write_markers(8'hA5, 8'h5A, 8'h5A, 8'hA5);
            endcase
            if (setting < 2)
            begin
                send_idle_pct = 36;
                recv_idle_pct = 52;
            end
            else if (setting < 4)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 36;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (setting == 2)
            begin
                queue_frame(8'd255, 8'($urandom_range(0, 255)), 1'b1, CLOSE_GOOD);
            end
            random_traffic(225);
        end
        drain_link();

        $display("Sent %0d bytes under six marker settings and three idling patterns.",
                 bytes_sent);
        $display("Checked %0d payload bytes and %0d reports (%0d good, %0d CRC, %0d end).",
                 payloads_checked, reports_checked, report_tally[0], report_tally[1],
                 report_tally[2]);
        if (error_count == 0 && frame_events_due.size() == 0)
        begin
            $display("framed_packet_receiver test passed");
        end
        else
        begin
            $display("framed_packet_receiver test failed");
        end
        $finish;
    end

endmodule
